[design/assert_macros.svh]
// Assertion macros used by the framer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define SDCF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define SDCF_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/sdcf_pkg.sv]
// Package with types, constants and the CRC7 step function of the SD SPI command framer.
`timescale 1ns / 1ps
`default_nettype none
package sdcf_pkg;

	localparam logic       OP_START       = 1'b0;
	localparam logic       OP_RX          = 1'b1;

	localparam logic       CFG_CRC_ENABLE = 1'b0;
	localparam logic       CFG_WAIT_LIMIT = 1'b1;

	localparam logic [7:0] FILL_BYTE      = 8'hFF;
	localparam logic [7:0] CMD_START_BITS = 8'h40;
	localparam logic [7:0] CMD_BYTE_MASK  = 8'h7F;
	localparam logic [7:0] CMD0_TRAILER   = 8'h95;
	localparam logic [7:0] OTHER_TRAILER  = 8'h00;
	localparam logic [6:0] CRC7_POLY      = 7'h09;
	localparam logic [7:0] WAIT_LIMIT_RST = 8'd8;

	localparam logic [2:0] LAST_BYTE_IDX  = 3'd6;

	localparam logic [1:0] RESP_R1        = 2'd0;
	localparam logic [1:0] RESP_R1B       = 2'd1;
	localparam logic [1:0] RESP_R2        = 2'd2;
	localparam logic [1:0] RESP_R3        = 2'd3;

	typedef enum logic [1:0] {
		KIND_TX      = 2'd0,
		KIND_DONE    = 2'd1,
		KIND_TIMEOUT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_FIRST = 2'd1,
		PH_TAIL  = 2'd2
	} phase_t;

	typedef struct packed {
		logic        op;
		logic [5:0]  cmd_index;
		logic [31:0] argument;
		logic [1:0]  resp_type;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic        fire;
		kind_t       kind;
		logic [7:0]  first;
		logic [31:0] rest;
		logic [2:0]  len;
	} resp_evt_t;

	// Advances the CRC7 register over one byte, most significant bit first.
	function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] data);
		logic [6:0] c;
		logic       fb;
		c = crc_in;
		for (int i = 7; i >= 0; i--) begin
			fb = c[6] ^ data[i];
			c = {c[5:0], 1'b0};
			if (fb) begin
				c = c ^ CRC7_POLY;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

[design/sdcf_item_if.sv]
// Channel interface that carries command and received-byte items.
`timescale 1ns / 1ps
`default_nettype none
interface sdcf_item_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [5:0]  cmd_index;
	logic [31:0] argument;
	logic [1:0]  resp_type;
	logic [7:0]  rx_byte;

	modport source (output valid, output op, output cmd_index, output argument,
		output resp_type, output rx_byte, input ready);
	modport sink (input valid, input op, input cmd_index, input argument,
		input resp_type, input rx_byte, output ready);
endinterface
`default_nettype wire

[design/sdcf_result_if.sv]
// Channel interface that carries frame bytes and response results.
`timescale 1ns / 1ps
`default_nettype none
interface sdcf_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  tx_byte;
	logic        last_tx;
	logic [7:0]  resp_first;
	logic [31:0] resp_rest;
	logic [2:0]  resp_len;

	modport source (output valid, output kind, output tx_byte, output last_tx,
		output resp_first, output resp_rest, output resp_len, input ready);
	modport sink (input valid, input kind, input tx_byte, input last_tx,
		input resp_first, input resp_rest, input resp_len, output ready);
endinterface
`default_nettype wire

[design/sdcf_frame_gen.sv]
// Frame byte sequencer with a running CRC7 over the command bytes.
`timescale 1ns / 1ps
`default_nettype none
module sdcf_frame_gen
	import sdcf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic        crc_enable,
	input  wire logic [5:0]  cmd_index,
	input  wire logic [31:0] argument,
	output logic [7:0]       tx_byte,
	output logic             last
);

	logic [2:0] byte_idx_q;
	logic [6:0] crc_q;

	always_comb begin
		unique case (byte_idx_q)
			3'd0: tx_byte = FILL_BYTE;
			3'd1: tx_byte = (CMD_START_BITS | {2'b00, cmd_index}) & CMD_BYTE_MASK;
			3'd2: tx_byte = argument[31:24];
			3'd3: tx_byte = argument[23:16];
			3'd4: tx_byte = argument[15:8];
			3'd5: tx_byte = argument[7:0];
			default: begin
				if (crc_enable) begin
					tx_byte = {crc_q, 1'b1};
				end else begin
					tx_byte = (cmd_index == 6'd0) ? CMD0_TRAILER : OTHER_TRAILER;
				end
			end
		endcase
	end

	assign last = (byte_idx_q == LAST_BYTE_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_idx_q <= 3'd0;
			crc_q <= 7'd0;
		end else if (step) begin
			if (last) begin
				byte_idx_q <= 3'd0;
				crc_q <= 7'd0;
			end else begin
				byte_idx_q <= byte_idx_q + 3'd1;
				if (byte_idx_q != 3'd0) begin
					crc_q <= crc7_byte(crc_q, tx_byte);
				end
			end
		end
	end

endmodule
`default_nettype wire

[design/sdcf_resp_track.sv]
// Response tracker: skips idle bytes or times out; takes status byte and tail.
`timescale 1ns / 1ps
`default_nettype none
module sdcf_resp_track
	import sdcf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [1:0] resp_type,
	input  wire logic       rx_go,
	input  wire logic [7:0] rx_byte,
	input  wire logic [7:0] wait_limit,
	output resp_evt_t       evt
);

	phase_t      phase_q, phase_d;
	logic [7:0]  idle_count_q, idle_count_d;
	logic [2:0]  bytes_left_q, bytes_left_d;
	logic [1:0]  pending_type_q, pending_type_d;
	logic [7:0]  first_byte_q, first_byte_d;
	logic [31:0] tail_bytes_q, tail_bytes_d;
	logic [2:0]  bytes_left_dec;
	logic [31:0] tail_shifted;

	assign bytes_left_dec = (bytes_left_q != 3'd0) ? bytes_left_q - 3'd1 : 3'd0;
	assign tail_shifted = {tail_bytes_q[23:0], rx_byte};

	always_comb begin
		phase_d = phase_q;
		idle_count_d = idle_count_q;
		bytes_left_d = bytes_left_q;
		pending_type_d = pending_type_q;
		first_byte_d = first_byte_q;
		tail_bytes_d = tail_bytes_q;
		if (start) begin
			phase_d = PH_FIRST;
			idle_count_d = 8'd0;
			pending_type_d = resp_type;
			bytes_left_d = (resp_type == RESP_R2) ? 3'd1 :
				((resp_type == RESP_R3) ? 3'd4 : 3'd0);
			first_byte_d = FILL_BYTE;
			tail_bytes_d = 32'd0;
		end else if (rx_go) begin
			unique case (phase_q)
				PH_FIRST: begin
					if (rx_byte == FILL_BYTE) begin
						if (idle_count_q >= wait_limit) begin
							phase_d = PH_IDLE;
						end else begin
							idle_count_d = idle_count_q + 8'd1;
						end
					end else begin
						first_byte_d = rx_byte;
						phase_d = (bytes_left_q == 3'd0) ? PH_IDLE : PH_TAIL;
					end
				end
				PH_TAIL: begin
					tail_bytes_d = tail_shifted;
					bytes_left_d = bytes_left_dec;
					if (bytes_left_dec == 3'd0) begin
						phase_d = PH_IDLE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		evt = '{fire: 1'b0, kind: KIND_DONE, first: 8'd0, rest: 32'd0, len: 3'd0};
		unique case (phase_q)
			PH_FIRST: begin
				if (rx_byte == FILL_BYTE) begin
					if (idle_count_q >= wait_limit) begin
						evt.fire = 1'b1;
						evt.kind = KIND_TIMEOUT;
						evt.first = FILL_BYTE;
					end
				end else if (bytes_left_q == 3'd0) begin
					evt.fire = 1'b1;
					evt.first = rx_byte;
					evt.len = 3'd1;
				end
			end
			PH_TAIL: begin
				if (bytes_left_dec == 3'd0) begin
					evt.fire = 1'b1;
					evt.first = first_byte_q;
					evt.rest = tail_shifted;
					evt.len = (pending_type_q == RESP_R3) ? 3'd5 : 3'd2;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idle_count_q <= 8'd0;
			bytes_left_q <= 3'd0;
			pending_type_q <= RESP_R1;
			first_byte_q <= FILL_BYTE;
			tail_bytes_q <= 32'd0;
		end else begin
			phase_q <= phase_d;
			idle_count_q <= idle_count_d;
			bytes_left_q <= bytes_left_d;
			pending_type_q <= pending_type_d;
			first_byte_q <= first_byte_d;
			tail_bytes_q <= tail_bytes_d;
		end
	end

endmodule
`default_nettype wire

[design/sd_spi_command_framer_core.sv]
// Top level of the SD SPI command framer: input stage, frame and response logic, result register.
//
// Channel  Role    Transaction
// item     sink    start command (op 0) or one byte received from the card (op 1)
// result   source  frame byte, response complete or response timeout
//
// A received byte leaves the input stage as soon as result can advance, so such items flow back to back unless stalled.
// A start command holds the input stage until all seven frame bytes are out, since the result
// register takes one frame byte per cycle and the CRC7 advances one byte per cycle, unless stalled.
// Results appear in the cycle after the work that makes them; a stall on result holds both stages.
// Reset clears the control state and sets the registers to CRC on and a wait limit of 8.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sd_spi_command_framer_core
	import sdcf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_wdata,
	sdcf_item_if.sink       item,
	sdcf_result_if.source   result
);

	logic        crc_enable_q;
	logic [7:0]  wait_limit_q;
	item_t       item_s1;
	logic        valid_s1;
	logic        advance;
	logic        is_start;
	logic        frame_step;
	logic        frame_last;
	logic        start_go;
	logic        rx_go;
	logic [7:0]  frame_byte;
	resp_evt_t   evt;

	logic        valid_s2;
	kind_t       kind_s2;
	logic [7:0]  tx_byte_s2;
	logic        last_tx_s2;
	logic [7:0]  resp_first_s2;
	logic [31:0] resp_rest_s2;
	logic [2:0]  resp_len_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_enable_q <= 1'b1;
			wait_limit_q <= WAIT_LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_CRC_ENABLE: crc_enable_q <= cfg_wdata[0];
				CFG_WAIT_LIMIT: wait_limit_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign advance = !valid_s2 || result.ready;
	assign is_start = (item_s1.op == OP_START);
	assign frame_step = valid_s1 && is_start && advance;
	assign start_go = frame_step && frame_last;
	assign rx_go = valid_s1 && !is_start && advance;
	assign item.ready = !valid_s1 || rx_go || start_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= '{op: item.op, cmd_index: item.cmd_index, argument: item.argument,
				resp_type: item.resp_type, rx_byte: item.rx_byte};
		end
	end

	sdcf_frame_gen u_frame_gen (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (frame_step),
		.crc_enable (crc_enable_q),
		.cmd_index  (item_s1.cmd_index),
		.argument   (item_s1.argument),
		.tx_byte    (frame_byte),
		.last       (frame_last)
	);

	sdcf_resp_track u_resp_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start_go),
		.resp_type  (item_s1.resp_type),
		.rx_go      (rx_go),
		.rx_byte    (item_s1.rx_byte),
		.wait_limit (wait_limit_q),
		.evt        (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= frame_step || (rx_go && evt.fire);
		end
	end

	always_ff @(posedge clk) begin
		if (frame_step) begin
			kind_s2 <= KIND_TX;
			tx_byte_s2 <= frame_byte;
			last_tx_s2 <= frame_last;
			resp_first_s2 <= 8'd0;
			resp_rest_s2 <= 32'd0;
			resp_len_s2 <= 3'd0;
		end else if (rx_go && evt.fire) begin
			kind_s2 <= evt.kind;
			tx_byte_s2 <= 8'd0;
			last_tx_s2 <= 1'b0;
			resp_first_s2 <= evt.first;
			resp_rest_s2 <= evt.rest;
			resp_len_s2 <= evt.len;
		end
	end

	assign result.valid = valid_s2;
	assign result.kind = kind_s2;
	assign result.tx_byte = tx_byte_s2;
	assign result.last_tx = last_tx_s2;
	assign result.resp_first = resp_first_s2;
	assign result.resp_rest = resp_rest_s2;
	assign result.resp_len = resp_len_s2;

	`SDCF_ASSERT(a_start_holds_input, valid_s1 && is_start && !frame_last |-> !item.ready, "input taken during frame")
	`SDCF_ASSERT(a_done_len_legal, result.valid && result.kind == KIND_DONE |-> result.resp_len == 3'd1 || result.resp_len == 3'd2 || result.resp_len == 3'd5, "illegal response length")
	`SDCF_ASSERT(a_last_then_fresh, result.valid && result.ready && result.last_tx |=> !(result.valid && result.last_tx), "frame end repeated")

endmodule
`default_nettype wire
